// ----- hdl/polyline_stroke_quad_generator_defines.svh -----
// assertion macros for the polyline stroke quad generator
// used by the top level and the iterative math unit
`ifndef POLYLINE_STROKE_QUAD_GENERATOR_DEFINES_SVH
`define POLYLINE_STROKE_QUAD_GENERATOR_DEFINES_SVH

// a condition that must hold at every clock edge outside reset
`define PSQ_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// an antecedent at one edge implies a consequent at the next edge
`define PSQ_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/psqg_pkg.sv -----
// shared types and constants for the polyline stroke quad generator
// no dependencies
package psqg_pkg;
   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 4;
   localparam int HT_BITS        = 15;
   localparam logic [HT_BITS-1:0] HT_RESET = 15'd768;
   localparam int CSR_ADDR_BITS  = 2;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_HALF_THICKNESS = 2'd0;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQRT, ST_DIVX, ST_DIVY, ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE, OP_SQRT, OP_DIV
   } op_type;

   typedef struct packed {
      logic start;
      op_type op;
   } math_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } math_sts_type;
endpackage

// ----- hdl/psqg_math.sv -----
// iterative unit: integer square root (two bits a step) and restoring division
// (one bit a step), one operation at a time; uses psqg_pkg
`include "polyline_stroke_quad_generator_defines.svh"
module psqg_math
   import psqg_pkg::*;
#(
   parameter int W = 34
) (
   input  logic                  clock,
   input  logic                  reset,
   input  math_ctl_type          ctl,
   input  logic [2*W-1:0]        arg_a,
   input  logic [W-1:0]          arg_b,
   output math_sts_type          sts,
   output logic [2*W-1:0]        result
);
   localparam int SW = 2 * W;
   localparam int CW = $clog2(SW + 1);

   logic [SW-1:0] acc_ff, acc_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [SW-1:0] quo_ff, quo_in;
   logic [W-1:0]  div_ff, div_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   op_type        op_ff, op_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [SW+1:0] trial;
   logic [SW:0]   rem_sh;
   logic [SW-1:0] sq_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_NONE;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sq_bit  = '0;
      trial   = '0;
      rem_sh  = '0;
      if (ctl.start && !busy_ff) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         acc_in  = arg_a;
         rem_in  = '0;
         quo_in  = '0;
         div_in  = arg_b;
         cnt_in  = (ctl.op == OP_SQRT) ? CW'(W) : CW'(SW);
      end else if (busy_ff) begin
         case (op_ff)
            OP_SQRT: begin
               // acc holds s, quo holds r, one two-bit step per cycle
               sq_bit = SW'(1) << (2 * (cnt_ff - CW'(1)));
               trial  = (SW+2)'(quo_ff) + (SW+2)'(sq_bit);
               if ((SW+2)'(acc_ff) >= trial) begin
                  acc_in = acc_ff - trial[SW-1:0];
                  quo_in = (quo_ff >> 1) + sq_bit;
               end else begin
                  quo_in = quo_ff >> 1;
               end
            end
            default: begin
               rem_sh = {rem_ff, acc_ff[SW-1]};
               acc_in = acc_ff << 1;
               if (rem_sh >= (SW+1)'(div_ff)) begin
                  rem_in = SW'(rem_sh - (SW+1)'(div_ff));
                  quo_in = {quo_ff[SW-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh[SW-1:0];
                  quo_in = {quo_ff[SW-2:0], 1'b0};
               end
            end
         endcase
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = quo_ff;

   `PSQ_ALWAYS(a_done_not_busy, clock, reset, !(done_ff && busy_ff), "done while busy")
   `PSQ_NEXT(a_start_busy, clock, reset, ctl.start && !busy_ff, busy_ff, "start not taken")
   `PSQ_ALWAYS(a_cnt_live, clock, reset, !busy_ff || cnt_ff != '0, "zero count while busy")
endmodule

// ----- hdl/polyline_stroke_quad_generator.sv -----
// top level of the polyline stroke quad generator: waypoint stream in,
// strip vertex stream out, csr port; uses psqg_pkg and psqg_math
//
// usage
//   req_ takes one waypoint per item: tdata = point_x, point_y; tuser = path_end.
//   each waypoint after the first of a path gives four vertices on rsp_,
//   corners 0..3 in order; tlast = last_of_run, tuser = strip_done.
//   the first waypoint of a path is stored and gives nothing.
//   csr_ register 0 at byte 0 is half_thickness (reset 768); write it while idle.
// processing
//   a segment takes one square root (two bits a step) and, unless its length
//   is zero, two divisions (one bit a step) on the shared math unit, then
//   emits four vertices. req_tready is low while a segment is in work.
// reset and stall
//   reset clears the stored point and the half thickness goes to 768.
//   a stall on rsp_ holds the current vertex; no item is lost.
`include "polyline_stroke_quad_generator_defines.svh"
module polyline_stroke_quad_generator
   import psqg_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // point_x [COORD_BITS-1:0], point_y above it
   input  logic [2*COORD_BITS-1:0]   req_tdata,
   // path_end
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // vertex_x, vertex_y, corner (2 bits), zero fill to bytes
   output logic [((2*COORD_BITS+2+7)/8)*8-1:0] rsp_tdata,
   // last_of_run
   output logic                      rsp_tlast,
   // strip_done
   output logic                      rsp_tuser,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   localparam int CB = COORD_BITS;
   localparam int DB = CB + 1;            // difference width
   localparam int MW = DB + 1;            // math unit width
   localparam int SW = 2 * MW;
   localparam int OW = ((2*CB+2+7)/8)*8;
   localparam int VB = CB + 3;            // vertex sum width
   localparam logic signed [VB-1:0] VMAX = VB'((64'sd1 <<< (CB-1)) - 64'sd1);
   localparam logic signed [VB-1:0] VMIN = -VMAX - VB'(1);

   state_type state_ff, state_in;
   logic [HT_BITS-1:0] ht_ff;
   logic signed [CB-1:0] px_ff, py_ff, cx_ff, cy_ff;
   logic signed [CB-1:0] cx_in, cy_in, px_in, py_in;
   logic have_ff, have_in, seen_ff, seen_in, last_ff, last_in;
   logic [DB-1:0] adx_ff, ady_ff, adx_in, ady_in;
   logic sx_ff, sy_ff, sx_in, sy_in;
   logic [MW-1:0] len_ff, len_in;
   logic signed [DB:0] ux_ff, uy_ff, ux_in, uy_in;
   logic [1:0] k_ff, k_in;
   logic go_ff, go_in;

   math_ctl_type mctl;
   math_sts_type msts;
   logic [SW-1:0] ma, mres;
   logic [MW-1:0] mb;

   logic signed [DB:0] dxs, dys;
   logic [DB-1:0] amag;
   logic [SW-1:0] prod;
   logic signed [VB-1:0] base_x, base_y, vx, vy;
   logic signed [CB-1:0] ox, oy;

   logic wr_en;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_HALF_THICKNESS) ? 32'(ht_ff) : '0;

   psqg_math #(.W(MW)) u_math (
      .clock(clock), .reset(reset), .ctl(mctl),
      .arg_a(ma), .arg_b(mb), .sts(msts), .result(mres)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ht_ff    <= HT_RESET;
         have_ff  <= 1'b0;
         seen_ff  <= 1'b0;
         px_ff    <= '0;
         py_ff    <= '0;
         go_ff    <= 1'b0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (wr_en && csr_paddr == ADDR_HALF_THICKNESS) ht_ff <= csr_pwdata[HT_BITS-1:0];
         have_ff  <= have_in;
         seen_ff  <= seen_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         go_ff    <= go_in;
         k_ff     <= k_in;
      end
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      last_ff <= last_in;
      adx_ff <= adx_in;
      ady_ff <= ady_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      len_ff <= len_in;
      ux_ff  <= ux_in;
      uy_ff  <= uy_in;
   end

   assign dxs = (DB+1)'(signed'(req_tdata[CB-1:0])) - (DB+1)'(px_ff);
   assign dys = (DB+1)'(signed'(req_tdata[2*CB-1:CB])) - (DB+1)'(py_ff);
   assign amag = (state_ff == ST_DIVX) ? adx_ff : ady_ff;
   assign prod = SW'(amag) * SW'(ht_ff);

   always_comb begin
      state_in = state_ff;
      cx_in = cx_ff; cy_in = cy_ff; px_in = px_ff; py_in = py_ff;
      have_in = have_ff; seen_in = seen_ff; last_in = last_ff;
      adx_in = adx_ff; ady_in = ady_ff; sx_in = sx_ff; sy_in = sy_ff;
      len_in = len_ff; ux_in = ux_ff; uy_in = uy_ff; k_in = k_ff;
      go_in = 1'b0;
      req_tready = 1'b0;
      mctl.start = 1'b0;
      mctl.op = OP_NONE;
      ma = '0;
      mb = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (!have_ff) begin
                  if (!req_tuser) begin
                     px_in = signed'(req_tdata[CB-1:0]);
                     py_in = signed'(req_tdata[2*CB-1:CB]);
                     have_in = 1'b1;
                  end
                  seen_in = 1'b0;
               end else begin
                  cx_in = signed'(req_tdata[CB-1:0]);
                  cy_in = signed'(req_tdata[2*CB-1:CB]);
                  last_in = req_tuser;
                  sx_in = dxs[DB];
                  sy_in = dys[DB];
                  adx_in = dxs[DB] ? DB'(-dxs) : dxs[DB-1:0];
                  ady_in = dys[DB] ? DB'(-dys) : dys[DB-1:0];
                  go_in = 1'b1;
                  state_in = ST_SQRT;
               end
            end
         end
         ST_SQRT: begin
            mctl.op = OP_SQRT;
            mctl.start = go_ff;
            ma = SW'(adx_ff) * SW'(adx_ff) + SW'(ady_ff) * SW'(ady_ff);
            if (msts.done) begin
               len_in = mres[MW-1:0];
               go_in = 1'b1;
               state_in = ST_DIVX;
            end
         end
         ST_DIVX, ST_DIVY: begin
            mctl.op = OP_DIV;
            mctl.start = go_ff && (len_ff != '0);
            ma = prod + SW'(len_ff >> 1);
            mb = len_ff;
            if (msts.done || (go_ff && len_ff == '0)) begin
               if (state_ff == ST_DIVX) begin
                  ux_in = (len_ff == '0) ? '0 : (sx_ff ? -(DB+1)'(mres) : (DB+1)'(mres));
                  go_in = 1'b1;
                  state_in = ST_DIVY;
               end else begin
                  uy_in = (len_ff == '0) ? '0 : (sy_ff ? -(DB+1)'(mres) : (DB+1)'(mres));
                  k_in = '0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               k_in = k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  state_in = ST_IDLE;
                  if (last_ff) begin
                     have_in = 1'b0;
                     seen_in = 1'b0;
                  end else begin
                     px_in = cx_ff;
                     py_in = cy_ff;
                     seen_in = 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // vertex assembly, one corner per cycle while rsp_tready is high
   always_comb begin
      if (k_ff[1]) begin
         base_x = VB'(cx_ff) + (last_ff ? VB'(ux_ff) : '0);
         base_y = VB'(cy_ff) + (last_ff ? VB'(uy_ff) : '0);
      end else begin
         base_x = VB'(px_ff) - (seen_ff ? '0 : VB'(ux_ff));
         base_y = VB'(py_ff) - (seen_ff ? '0 : VB'(uy_ff));
      end
      if (k_ff[0]) begin
         vx = base_x + VB'(uy_ff);
         vy = base_y - VB'(ux_ff);
      end else begin
         vx = base_x - VB'(uy_ff);
         vy = base_y + VB'(ux_ff);
      end
      ox = (vx > VMAX) ? VMAX[CB-1:0] : (vx < VMIN) ? VMIN[CB-1:0] : vx[CB-1:0];
      oy = (vy > VMAX) ? VMAX[CB-1:0] : (vy < VMIN) ? VMIN[CB-1:0] : vy[CB-1:0];
   end

   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = OW'({k_ff, oy, ox});
   assign rsp_tlast  = (k_ff == 2'd3);
   assign rsp_tuser  = (k_ff == 2'd3) && last_ff;

   `PSQ_ALWAYS(a_no_req_busy, clock, reset, !(req_tready && state_ff != ST_IDLE),
      "ready outside idle")
   `PSQ_NEXT(a_emit_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(k_ff), "stalled vertex changed")
   `PSQ_ALWAYS(a_math_idle, clock, reset, !(state_ff == ST_EMIT && msts.busy),
      "math busy during output")
endmodule
